/* rtl/lltp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lltp_pkg
// Shared types, character constants and helpers for the log line timestamp
// parser: request/response payloads, parse phases, format and unit codes.
// ----------------------------------------------------------------------------
package lltp_pkg;

   localparam int unsigned VALUE_W = 63;
   localparam int unsigned MULT_W  = 30;

   localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_AT      = 8'h40;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UP_A    = 8'h41;
   localparam logic [7:0] CH_UP_Z    = 8'h5A;
   localparam logic [7:0] CH_LO_A    = 8'h61;
   localparam logic [7:0] CH_LO_Z    = 8'h7A;
   localparam logic [7:0] CH_CASE    = 8'h20;
   localparam logic [7:0] CH_LO_T    = 8'h74;
   localparam logic [7:0] CH_LO_I    = 8'h69;
   localparam logic [7:0] CH_LO_M    = 8'h6D;
   localparam logic [7:0] CH_LO_E    = 8'h65;
   localparam logic [7:0] CH_LO_N    = 8'h6E;
   localparam logic [7:0] CH_LO_P    = 8'h70;
   localparam logic [7:0] CH_LO_F    = 8'h66;
   localparam logic [7:0] CH_LO_U    = 8'h75;
   localparam logic [7:0] CH_LO_S    = 8'h73;

   localparam logic [MULT_W-1:0] MULT_ONE  = MULT_W'(1);
   localparam logic [MULT_W-1:0] MULT_KILO = MULT_W'(1000);
   localparam logic [MULT_W-1:0] MULT_MEGA = MULT_W'(1000000);
   localparam logic [MULT_W-1:0] MULT_GIGA = MULT_W'(1000000000);

   typedef struct packed {
      logic       char_valid;
      logic [7:0] character;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [VALUE_W-1:0] timestamp;
      logic               clamped;
   } rsp_type;

   typedef enum logic [15:0] {
      PH_START      = 16'h0001,
      PH_LEAD_WS    = 16'h0002,
      PH_DIGITS     = 16'h0004,
      PH_BR_WS      = 16'h0008,
      PH_BR_DIGITS  = 16'h0010,
      PH_BR_WAIT    = 16'h0020,
      PH_TIME_I     = 16'h0040,
      PH_TIME_M     = 16'h0080,
      PH_TIME_E     = 16'h0100,
      PH_TIME_SEP   = 16'h0200,
      PH_NUM_DIGITS = 16'h0400,
      PH_SUF_WS     = 16'h0800,
      PH_UNIT_ONE   = 16'h1000,
      PH_UNIT_TWO   = 16'h2000,
      PH_DONE       = 16'h4000,
      PH_REJECT     = 16'h8000
   } phase_type;

   typedef enum logic [2:0] {
      FMT_NONE    = 3'd0,
      FMT_MARK    = 3'd1,
      FMT_BRACKET = 3'd2,
      FMT_TIME    = 3'd3,
      FMT_NUMBER  = 3'd4
   } format_type;

   typedef enum logic [2:0] {
      U_NONE = 3'd0,
      U_N    = 3'd1,
      U_P    = 3'd2,
      U_F    = 3'd3,
      U_U    = 3'd4,
      U_M    = 3'd5,
      U_S    = 3'd6
   } unit_type;

   typedef enum logic [1:0] {
      SC_ONE  = 2'd0,
      SC_KILO = 2'd1,
      SC_MEGA = 2'd2,
      SC_GIGA = 2'd3
   } scale_type;

   // One finished line as handed from the character parser to the scaler.
   typedef struct packed {
      logic               found;
      logic [VALUE_W-1:0] value;
      logic               ovf;
      scale_type          scale;
   } fin_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[CH_ZERO:CH_NINE]};
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c inside {[CH_UP_A:CH_UP_Z]}) ? (c + CH_CASE) : c;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return to_lower(c) inside {[CH_LO_A:CH_LO_Z]};
   endfunction

   function automatic unit_type first_unit(input logic [7:0] c);
      unit_type u;
      case (to_lower(c))
         CH_LO_N: u = U_N;
         CH_LO_P: u = U_P;
         CH_LO_F: u = U_F;
         CH_LO_U: u = U_U;
         CH_LO_M: u = U_M;
         CH_LO_S: u = U_S;
         default: u = U_NONE;
      endcase
      return u;
   endfunction

   function automatic logic [MULT_W-1:0] scale_factor(input scale_type s);
      logic [MULT_W-1:0] m;
      case (s)
         SC_ONE:  m = MULT_ONE;
         SC_KILO: m = MULT_KILO;
         SC_MEGA: m = MULT_MEGA;
         SC_GIGA: m = MULT_GIGA;
         default: m = MULT_ONE;
      endcase
      return m;
   endfunction

endpackage
`default_nettype wire

/* rtl/lltp_char_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lltp_char_parser
// Per-character parse state machine: format pick, digit accumulation with
// saturation, unit word decode; presents the finished line on line end.
// ----------------------------------------------------------------------------
module lltp_char_parser
   import lltp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    take,
   input  req_type item,
   output fin_type fin
);

   phase_type          phase_ff, phase_in;
   format_type         format_ff, format_in;
   unit_type           unit_ff, unit_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               ovf_ff, ovf_in;
   logic               closed_ff, closed_in;
   logic               seen_ff, seen_in;

   logic [7:0]         c;
   logic [7:0]         lc;
   logic               do_digit;
   logic [VALUE_W+3:0] dig_sum;
   logic               dig_over;
   logic               found;
   scale_type          scale;

   assign c  = item.character;
   assign lc = to_lower(c);

   // acc*10 + digit, wide enough to see overflow past the maximum
   assign dig_sum  = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                   + {{VALUE_W{1'b0}}, c[3:0]};
   assign dig_over = |dig_sum[VALUE_W+3:VALUE_W];

   always_comb begin
      phase_in  = phase_ff;
      format_in = format_ff;
      unit_in   = unit_ff;
      acc_in    = acc_ff;
      ovf_in    = ovf_ff;
      closed_in = closed_ff;
      seen_in   = seen_ff;
      do_digit  = 1'b0;

      if (item.char_valid) begin
         case (phase_ff)
            PH_START: begin
               if (is_ws(c)) begin
                  phase_in = PH_START;
               end else if (c == CH_HASH || c == CH_AT) begin
                  format_in = FMT_MARK;
                  phase_in  = PH_LEAD_WS;
               end else if (c == CH_LBRACK) begin
                  format_in = FMT_BRACKET;
                  phase_in  = PH_BR_WS;
               end else if (lc == CH_LO_T) begin
                  format_in = FMT_TIME;
                  phase_in  = PH_TIME_I;
               end else if (is_digit(c)) begin
                  format_in = FMT_NUMBER;
                  phase_in  = PH_NUM_DIGITS;
                  do_digit  = 1'b1;
               end else begin
                  phase_in = PH_REJECT;
               end
            end
            PH_LEAD_WS: begin
               if (is_ws(c)) begin
                  phase_in = PH_LEAD_WS;
               end else if (is_digit(c)) begin
                  phase_in = PH_DIGITS;
                  do_digit = 1'b1;
               end else begin
                  phase_in = PH_REJECT;
               end
            end
            PH_DIGITS: begin
               if (is_digit(c)) do_digit = 1'b1;
               else phase_in = PH_DONE;
            end
            PH_BR_WS: begin
               if (is_ws(c)) begin
                  phase_in = PH_BR_WS;
               end else if (is_digit(c)) begin
                  phase_in = PH_BR_DIGITS;
                  do_digit = 1'b1;
               end else begin
                  phase_in = PH_REJECT;
               end
            end
            PH_BR_DIGITS: begin
               if (is_digit(c)) begin
                  do_digit = 1'b1;
               end else if (c == CH_RBRACK) begin
                  closed_in = 1'b1;
                  phase_in  = PH_DONE;
               end else begin
                  phase_in = PH_BR_WAIT;
               end
            end
            PH_BR_WAIT: begin
               if (c == CH_RBRACK) begin
                  closed_in = 1'b1;
                  phase_in  = PH_DONE;
               end
            end
            PH_TIME_I: phase_in = (lc == CH_LO_I) ? PH_TIME_M : PH_REJECT;
            PH_TIME_M: phase_in = (lc == CH_LO_M) ? PH_TIME_E : PH_REJECT;
            PH_TIME_E: phase_in = (lc == CH_LO_E) ? PH_TIME_SEP : PH_REJECT;
            PH_TIME_SEP: begin
               if (!is_ws(c)) begin
                  phase_in = (c == CH_COLON || c == CH_EQUAL) ? PH_LEAD_WS : PH_REJECT;
               end
            end
            PH_NUM_DIGITS, PH_SUF_WS: begin
               if (phase_ff == PH_NUM_DIGITS && is_digit(c)) begin
                  do_digit = 1'b1;
               end else if (is_ws(c)) begin
                  phase_in = PH_SUF_WS;
               end else if (is_alpha(c)) begin
                  unit_in  = first_unit(c);
                  phase_in = (first_unit(c) == U_NONE) ? PH_REJECT : PH_UNIT_ONE;
               end else begin
                  phase_in = PH_DONE;
               end
            end
            PH_UNIT_ONE: begin
               if (is_alpha(c)) begin
                  phase_in = (unit_ff != U_S && lc == CH_LO_S) ? PH_UNIT_TWO : PH_REJECT;
               end else begin
                  phase_in = (unit_ff == U_S) ? PH_DONE : PH_REJECT;
               end
            end
            PH_UNIT_TWO: phase_in = is_alpha(c) ? PH_REJECT : PH_DONE;
            default: phase_in = phase_ff;
         endcase
      end

      if (do_digit) begin
         seen_in = 1'b1;
         if (!ovf_ff) begin
            if (dig_over) begin
               acc_in = VALUE_MAX;
               ovf_in = 1'b1;
            end else begin
               acc_in = dig_sum[VALUE_W-1:0];
            end
         end
      end
   end

   // Line verdict from the state after this item's character
   always_comb begin
      case (phase_in)
         PH_DIGITS, PH_NUM_DIGITS, PH_SUF_WS, PH_UNIT_TWO: found = seen_in;
         PH_UNIT_ONE: found = seen_in && (unit_in == U_S);
         PH_DONE:     found = seen_in && (format_in != FMT_BRACKET || closed_in);
         default:     found = 1'b0;
      endcase

      scale = SC_ONE;
      if (found && format_in == FMT_NUMBER) begin
         case (unit_in)
            U_U:     scale = SC_KILO;
            U_M:     scale = SC_MEGA;
            U_S:     scale = SC_GIGA;
            default: scale = SC_ONE;
         endcase
      end

      fin.found = found;
      fin.value = found ? acc_in : '0;
      fin.ovf   = found && ovf_in;
      fin.scale = scale;
   end

   always_ff @(posedge clock) begin
      if (reset || (take && item.line_end)) begin
         phase_ff  <= PH_START;
         format_ff <= FMT_NONE;
         unit_ff   <= U_NONE;
         acc_ff    <= '0;
         ovf_ff    <= 1'b0;
         closed_ff <= 1'b0;
         seen_ff   <= 1'b0;
      end else if (take) begin
         phase_ff  <= phase_in;
         format_ff <= format_in;
         unit_ff   <= unit_in;
         acc_ff    <= acc_in;
         ovf_ff    <= ovf_in;
         closed_ff <= closed_in;
         seen_ff   <= seen_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/log_line_timestamp_parser_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// log_line_timestamp_parser_core
// Streams one text line a character per request and reports the leading
// timestamp of the line, scaled to nanoseconds, when the line ends.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req_data) carries one character
//   slot per request, with char_valid and line_end flags. Every request is
//   taken while req_stall is low; one character per cycle is sustained then.
//   Response channel (rsp_valid / rsp_stall / rsp_data) carries one response
//   per request with line_end set: found, timestamp, clamped.
//   Pipeline: a line-end request passes the parse into stage one, two
//   partial-product multiply stages for the unit scaling, and a final
//   add/compare into the output register.
//   Throughput: one request per cycle, line ends included, unless stalled;
//   the scaling pipeline is set by the 63 x 30 bit multiply split in two halves.
//   Stall: rsp_stall holds the output register; the stages behind it fill
//   bubbles first, and req_stall rises only when the first stage is full
//   and cannot advance.
//   Reset: synchronous, active high; clears the parse state and all stage
//   valid flags. No responses are pending after reset.
// ----------------------------------------------------------------------------
module log_line_timestamp_parser_core
   import lltp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   fin_type fin;
   logic    req_take;

   // stage load enables, from the output back to the input
   logic take_out, take3, take2, take1;

   // stage 1: finished line from the parser
   logic               v1_ff;
   logic               found1_ff;
   logic               ovf1_ff;
   logic [VALUE_W-1:0] acc1_ff;
   scale_type          scale1_ff;
   logic [MULT_W-1:0]  mult1;
   logic [61:0]        lo_prod;

   // stage 2: low partial product done, high half pending
   logic               v2_ff;
   logic               found2_ff;
   logic               ovf2_ff;
   logic [30:0]        hi_acc2_ff;
   logic [MULT_W-1:0]  mult2_ff;
   logic [61:0]        lo2_ff;
   logic [60:0]        hi_prod;

   // stage 3: both partial products
   logic               v3_ff;
   logic               found3_ff;
   logic               ovf3_ff;
   logic [60:0]        hi3_ff;
   logic [61:0]        lo3_ff;
   logic [93:0]        prod_full;
   logic               prod_over;
   rsp_type            rsp_in;

   // output register
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   assign take_out = !rsp_valid_ff || !rsp_stall;
   assign take3    = !v3_ff || take_out;
   assign take2    = !v2_ff || take3;
   assign take1    = !v1_ff || take2;

   assign req_stall = !take1;
   assign req_take  = req_valid && !req_stall;

   lltp_char_parser u_parser (
      .clock (clock),
      .reset (reset),
      .take  (req_take),
      .item  (req_data),
      .fin   (fin)
   );

   // Low half of acc times the unit factor
   assign mult1   = scale_factor(scale1_ff);
   assign lo_prod = {30'b0, acc1_ff[31:0]} * {32'b0, mult1};

   // High half of acc times the unit factor
   assign hi_prod = {30'b0, hi_acc2_ff} * {31'b0, mult2_ff};

   // Combine halves; anything at or above bit 63 means the scaled value
   // passed the maximum. An earlier digit overflow already holds the max.
   assign prod_full = {1'b0, hi3_ff, 32'b0} + {32'b0, lo3_ff};
   assign prod_over = |prod_full[93:VALUE_W];

   always_comb begin
      rsp_in.found     = found3_ff;
      rsp_in.timestamp = prod_over ? VALUE_MAX : prod_full[VALUE_W-1:0];
      rsp_in.clamped   = ovf3_ff || prod_over;
   end

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take1)    v1_ff        <= req_take && req_data.line_end;
         if (take2)    v2_ff        <= v1_ff;
         if (take3)    v3_ff        <= v2_ff;
         if (take_out) rsp_valid_ff <= v3_ff;
      end
   end

   // Payload: hold while the stage ahead is stalled
   always_ff @(posedge clock) begin
      if (take1) begin
         found1_ff <= fin.found;
         ovf1_ff   <= fin.ovf;
         acc1_ff   <= fin.value;
         scale1_ff <= fin.scale;
      end
      if (take2) begin
         found2_ff  <= found1_ff;
         ovf2_ff    <= ovf1_ff;
         hi_acc2_ff <= acc1_ff[VALUE_W-1:32];
         mult2_ff   <= mult1;
         lo2_ff     <= lo_prod;
      end
      if (take3) begin
         found3_ff <= found2_ff;
         ovf3_ff   <= ovf2_ff;
         hi3_ff    <= hi_prod;
         lo3_ff    <= lo2_ff;
      end
      if (take_out) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Stall the requester only when stage one is occupied
   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff)
      else $error("req_stall raised with stage one empty");

   // A finished stage three reaches the output when the output can take it
   a_stage3_moves: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && take_out) |=> rsp_valid_ff)
      else $error("stage three response lost");

   // A clamped response carries the saturated maximum and a found line
   a_clamp_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.clamped) |->
         (rsp_data_ff.found && rsp_data_ff.timestamp == VALUE_MAX))
      else $error("clamped response without maximum value");

   // Line end with free pipe lands in stage one on the next cycle
   a_line_end_enters: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_data.line_end) |=> v1_ff)
      else $error("line end request did not enter the pipeline");

endmodule
`default_nettype wire
